>>> rtl/sng_pkg.sv
// ----------------------------------------------------------------------------
// sng_pkg
// Shared types, constants and the microcode program of the stereo noise gate.
// ----------------------------------------------------------------------------
package sng_pkg;

  // default data widths
  localparam int SAMPLE_BITS = 16;
  localparam int HOLD_BITS   = 20;

  // fixed point
  localparam int ENV_W      = 32;
  localparam int GAIN_W     = 17;
  localparam int COEF_W     = 16;
  localparam int THR_W      = 16;
  localparam int HOLD_CFG_W = 20;
  localparam int GAIN_FRAC  = 16;
  localparam int THR_CMP_W  = THR_W + ENV_W;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = 17'h10000;
  localparam int unsigned       ROUND_HALF = 32768;

  // shared multiplier operand widths
  localparam int MUL_A_W = ENV_W + 2;
  localparam int MUL_B_W = GAIN_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_ATTACK  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_RELEASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_COUNT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ENV_ATTACK   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ENV_RELEASE  = 3'd6;

  localparam logic [THR_W-1:0]      THRESHOLD_RST    = 16'd1036;
  localparam logic [GAIN_W-1:0]     FLOOR_GAIN_RST   = 17'd0;
  localparam logic [COEF_W-1:0]     GAIN_ATTACK_RST  = 16'd64173;
  localparam logic [COEF_W-1:0]     GAIN_RELEASE_RST = 16'd65399;
  localparam logic [HOLD_CFG_W-1:0] HOLD_COUNT_RST   = 20'd2400;
  localparam logic [COEF_W-1:0]     ENV_ATTACK_RST   = 16'd53300;
  localparam logic [COEF_W-1:0]     ENV_RELEASE_RST  = 16'd65400;

  localparam logic [GAIN_W-1:0] GAIN_RST =
    (FLOOR_GAIN_RST > UNITY_GAIN) ? UNITY_GAIN : FLOOR_GAIN_RST;

  // sequencer steps
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_IDLE      = 4'd0;
  localparam logic [STEP_W-1:0] STEP_ENV_MUL   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_ENV_UPD   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_GATE      = 4'd3;
  localparam logic [STEP_W-1:0] STEP_GAIN_MUL  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_GAIN_UPD  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_LEFT_MUL  = 4'd6;
  localparam logic [STEP_W-1:0] STEP_RIGHT_MUL = 4'd7;
  localparam logic [STEP_W-1:0] STEP_OUT       = 4'd8;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_ENV,
    MUL_GAIN,
    MUL_LEFT,
    MUL_RIGHT
  } mul_sel_e;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_IN,
    COND_OUT
  } cond_e;

  typedef struct packed {
    mul_sel_e          mul_sel;
    logic              ld_env;
    logic              gate_upd;
    logic              ld_gain;
    logic              ld_left;
    logic              push;
    cond_e             cond;
    logic              jmp_en;
    logic [STEP_W-1:0] jmp_tgt;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
  } status_t;

  // microcode rom
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w         = '0;
    w.mul_sel = MUL_NONE;
    w.cond    = COND_NONE;
    case (step)
      STEP_IDLE:      w.cond     = COND_IN;
      STEP_ENV_MUL:   w.mul_sel  = MUL_ENV;
      STEP_ENV_UPD:   w.ld_env   = 1'b1;
      STEP_GATE:      w.gate_upd = 1'b1;
      STEP_GAIN_MUL:  w.mul_sel  = MUL_GAIN;
      STEP_GAIN_UPD:  w.ld_gain  = 1'b1;
      STEP_LEFT_MUL:  w.mul_sel  = MUL_LEFT;
      STEP_RIGHT_MUL: begin
        w.mul_sel = MUL_RIGHT;
        w.ld_left = 1'b1;
      end
      STEP_OUT: begin
        w.push    = 1'b1;
        w.cond    = COND_OUT;
        w.jmp_en  = 1'b1;
        w.jmp_tgt = STEP_IDLE;
      end
      default: begin
        w.jmp_en  = 1'b1;
        w.jmp_tgt = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

>>> rtl/sng_if.sv
// ----------------------------------------------------------------------------
// sng_if
// Frame channels of the stereo noise gate: input frames and gated frames.
// ----------------------------------------------------------------------------
interface sng_in_if #(
  parameter int SAMPLE_BITS = sng_pkg::SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;
  logic                          block_last;

  modport source (output valid, left_in, right_in, block_last, input ready);
  modport sink   (input valid, left_in, right_in, block_last, output ready);
endinterface

interface sng_out_if #(
  parameter int SAMPLE_BITS = sng_pkg::SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  logic                          gate_is_open;
  logic                          block_last_out;

  modport source (output valid, left_out, right_out, gate_is_open, block_last_out,
                  input ready);
  modport sink   (input valid, left_out, right_out, gate_is_open, block_last_out,
                  output ready);
endinterface

>>> rtl/sng_seq.sv
// ----------------------------------------------------------------------------
// sng_seq
// Step counter and microcode rom; stalls on a step until its condition holds.
// ----------------------------------------------------------------------------
module sng_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sng_pkg::status_t status_i,
  output sng_pkg::ctrl_t   ctrl_o
);

  logic [sng_pkg::STEP_W-1:0] step_q, step_d;
  logic                       cond_met;

  assign ctrl_o = sng_pkg::ucode(step_q);

  always_comb begin
    case (ctrl_o.cond)
      sng_pkg::COND_NONE: cond_met = 1'b1;
      sng_pkg::COND_IN:   cond_met = status_i.in_valid;
      sng_pkg::COND_OUT:  cond_met = status_i.out_free;
      default:            cond_met = 1'b1;
    endcase
  end

  always_comb begin
    if (!cond_met) begin
      step_d = step_q;
    end else if (ctrl_o.jmp_en) begin
      step_d = ctrl_o.jmp_tgt;
    end else begin
      step_d = step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= sng_pkg::STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

>>> rtl/stereo_noise_gate_core.sv
// ----------------------------------------------------------------------------
// stereo_noise_gate_core
// Stereo noise gate: peak envelope, hold timer, smoothed gate gain.
// ----------------------------------------------------------------------------
// Usage
//   in_if carries one stereo frame per word (left, right, block marker);
//   out_if returns the gated frame, the gate state and the marker copy.
//   Both are valid/ready channels; a word moves when both are high.
//   Configuration goes through cfg_we_i / cfg_idx_i / cfg_data_i while the
//   block is idle; unknown indexes are dropped.
// Timing
//   A frame runs through a 9-step microcode program on one shared
//   34x18 multiplier (envelope, gain, left, right): take, envelope
//   multiply and update, gate, gain multiply and update, left and right
//   multiply, push. A new frame is taken only back at the idle step.
// Reset
//   Configuration registers take their default values; envelope, hold timer
//   and gate flag clear and the gain starts at the saturated floor gain.
// Backpressure
//   A held output word stalls the program at its last step; input is taken
//   again once that word is gone.
// ----------------------------------------------------------------------------
module stereo_noise_gate_core #(
  parameter int SAMPLE_BITS = sng_pkg::SAMPLE_BITS,
  parameter int HOLD_BITS   = sng_pkg::HOLD_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sng_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sng_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  sng_in_if.sink                          in_if,
  sng_out_if.source                       out_if
);

  localparam int EnvFrac  = sng_pkg::ENV_W - SAMPLE_BITS;
  localparam int HoldExtW = (HOLD_BITS > sng_pkg::HOLD_CFG_W) ? HOLD_BITS
                                                             : sng_pkg::HOLD_CFG_W;
  localparam int MulAW    = sng_pkg::MUL_A_W;
  localparam int MulBW    = sng_pkg::MUL_B_W;
  localparam int ProdW    = sng_pkg::PROD_W;
  localparam int EnvW     = sng_pkg::ENV_W;
  localparam int GainW    = sng_pkg::GAIN_W;

  // configuration registers
  logic [sng_pkg::THR_W-1:0]      thr_q;
  logic [GainW-1:0]               floor_q;
  logic [sng_pkg::COEF_W-1:0]     gatk_q, grel_q, eatk_q, erel_q;
  logic [sng_pkg::HOLD_CFG_W-1:0] hold_cnt_q;

  // frame and state
  logic signed [SAMPLE_BITS-1:0] left_q, right_q, left_res_q;
  logic                          last_q;
  logic [EnvW-1:0]               env_q;
  logic [GainW-1:0]              gain_q, target_q;
  logic [HOLD_BITS-1:0]          hold_q;
  logic                          open_q;
  logic signed [ProdW-1:0]       prod_q;

  // output register
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_left_q, out_right_q;
  logic                          out_open_q, out_last_q;

  sng_pkg::ctrl_t   ctrl;
  sng_pkg::status_t status;
  logic             in_fire, out_free, push_fire;

  sng_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  assign in_if.ready     = (ctrl.cond == sng_pkg::COND_IN);
  assign in_fire         = in_if.valid && in_if.ready;
  assign out_free        = !out_valid_q || out_if.ready;
  assign push_fire       = ctrl.push && out_free;
  assign status.in_valid = in_if.valid;
  assign status.out_free = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= sng_pkg::THRESHOLD_RST;
      floor_q    <= sng_pkg::FLOOR_GAIN_RST;
      gatk_q     <= sng_pkg::GAIN_ATTACK_RST;
      grel_q     <= sng_pkg::GAIN_RELEASE_RST;
      hold_cnt_q <= sng_pkg::HOLD_COUNT_RST;
      eatk_q     <= sng_pkg::ENV_ATTACK_RST;
      erel_q     <= sng_pkg::ENV_RELEASE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sng_pkg::REG_THRESHOLD:    thr_q      <= cfg_data_i[sng_pkg::THR_W-1:0];
        sng_pkg::REG_FLOOR_GAIN:   floor_q    <= cfg_data_i[GainW-1:0];
        sng_pkg::REG_GAIN_ATTACK:  gatk_q     <= cfg_data_i[sng_pkg::COEF_W-1:0];
        sng_pkg::REG_GAIN_RELEASE: grel_q     <= cfg_data_i[sng_pkg::COEF_W-1:0];
        sng_pkg::REG_HOLD_COUNT:   hold_cnt_q <= cfg_data_i[sng_pkg::HOLD_CFG_W-1:0];
        sng_pkg::REG_ENV_ATTACK:   eatk_q     <= cfg_data_i[sng_pkg::COEF_W-1:0];
        sng_pkg::REG_ENV_RELEASE:  erel_q     <= cfg_data_i[sng_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // peak magnitude scaled to envelope units
  logic [SAMPLE_BITS-1:0] mag_l, mag_r, mag_pk;
  logic [EnvW-1:0]        peak;

  assign mag_l  = left_q[SAMPLE_BITS-1]  ? SAMPLE_BITS'(-left_q)  : SAMPLE_BITS'(left_q);
  assign mag_r  = right_q[SAMPLE_BITS-1] ? SAMPLE_BITS'(-right_q) : SAMPLE_BITS'(right_q);
  assign mag_pk = (mag_l > mag_r) ? mag_l : mag_r;
  assign peak   = EnvW'(mag_pk) << EnvFrac;

  // derived limits
  logic [GainW-1:0]                 floor_sat;
  logic [HoldExtW-1:0]              hold_ext, hold_max_ext, hold_sat_ext;
  logic [sng_pkg::THR_CMP_W-1:0]    thr_wide;

  assign floor_sat    = (floor_q > sng_pkg::UNITY_GAIN) ? sng_pkg::UNITY_GAIN : floor_q;
  assign hold_ext     = HoldExtW'(hold_cnt_q);
  assign hold_max_ext = HoldExtW'({HOLD_BITS{1'b1}});
  assign hold_sat_ext = (hold_ext > hold_max_ext) ? hold_max_ext : hold_ext;
  assign thr_wide     = sng_pkg::THR_CMP_W'(thr_q) << EnvFrac;

  // shared multiplier: smoothing is T + c*(old - T), rounded
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [MulAW-1:0] env_diff;
  logic signed [MulBW-1:0] gain_diff;
  logic [sng_pkg::COEF_W-1:0] env_coef, gain_coef;

  assign env_diff  = $signed({2'b00, env_q}) - $signed({2'b00, peak});
  assign gain_diff = $signed({1'b0, gain_q}) - $signed({1'b0, target_q});
  assign env_coef  = (peak > env_q) ? eatk_q : erel_q;
  assign gain_coef = (target_q > gain_q) ? gatk_q : grel_q;

  always_comb begin
    case (ctrl.mul_sel)
      sng_pkg::MUL_ENV: begin
        mul_a = env_diff;
        mul_b = $signed({2'b00, env_coef});
      end
      sng_pkg::MUL_GAIN: begin
        mul_a = MulAW'(gain_diff);
        mul_b = $signed({2'b00, gain_coef});
      end
      sng_pkg::MUL_LEFT: begin
        mul_a = MulAW'(left_q);
        mul_b = $signed({1'b0, gain_q});
      end
      sng_pkg::MUL_RIGHT: begin
        mul_a = MulAW'(right_q);
        mul_b = $signed({1'b0, gain_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  logic signed [ProdW-1:0] prod_rnd, env_sum, gain_sum;

  assign prod_rnd = (prod_q + $signed(ProdW'(sng_pkg::ROUND_HALF))) >>> sng_pkg::GAIN_FRAC;
  assign env_sum  = $signed(ProdW'(peak)) + prod_rnd;
  assign gain_sum = $signed(ProdW'(target_q)) + prod_rnd;

  // datapath payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      left_q  <= in_if.left_in;
      right_q <= in_if.right_in;
      last_q  <= in_if.block_last;
    end
    if (ctrl.mul_sel != sng_pkg::MUL_NONE) begin
      prod_q <= mul_a * mul_b;
    end
    if (ctrl.ld_left) begin
      left_res_q <= prod_rnd[SAMPLE_BITS-1:0];
    end
  end

  // filter and gate state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q    <= '0;
      gain_q   <= sng_pkg::GAIN_RST;
      hold_q   <= '0;
      open_q   <= 1'b0;
      target_q <= '0;
    end else begin
      if (ctrl.ld_env) begin
        env_q <= env_sum[EnvW-1:0];
      end
      if (ctrl.gate_upd) begin
        if (sng_pkg::THR_CMP_W'(env_q) > thr_wide) begin
          open_q   <= 1'b1;
          hold_q   <= hold_sat_ext[HOLD_BITS-1:0];
          target_q <= sng_pkg::UNITY_GAIN;
        end else if (hold_q != '0) begin
          hold_q   <= hold_q - 1'b1;
          target_q <= sng_pkg::UNITY_GAIN;
        end else begin
          open_q   <= 1'b0;
          target_q <= floor_sat;
        end
      end
      if (ctrl.ld_gain) begin
        gain_q <= gain_sum[GainW-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      out_left_q  <= left_res_q;
      out_right_q <= prod_rnd[SAMPLE_BITS-1:0];
      out_open_q  <= open_q;
      out_last_q  <= last_q;
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.left_out       = out_left_q;
  assign out_if.right_out      = out_right_q;
  assign out_if.gate_is_open   = out_open_q;
  assign out_if.block_last_out = out_last_q;

  // checks
  a_hold_implies_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hold_q != '0) |-> open_q)
    else $error("hold timer running with gate closed");

  a_gain_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ld_gain |=> (gain_q <= sng_pkg::UNITY_GAIN))
    else $error("gate gain above unity");

  a_one_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_if.ready)
    else $error("second frame taken while one is in work");

  a_result_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> ##8 ctrl.push)
    else $error("program did not reach the output step on time");

endmodule
